// ----- rtl/btkh_pkg.sv -----
// Shared types and constants of the bounded top-k heap block.
// Used by the controller, the datapath, the top level and the checker.
package btkh_pkg;

  localparam int CNT_W      = 7;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Operation codes on the input channel
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_POP = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE     = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED    = 3'd0,
    KIND_EVICTED  = 3'd1,
    KIND_REJECTED = 3'd2,
    KIND_POPPED   = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_e;

  // What an accepted item starts
  typedef enum logic [1:0] {
    CLS_NONE      = 2'd0,
    CLS_SIFT_UP   = 2'd1,
    CLS_SIFT_DOWN = 2'd2,
    CLS_POP       = 2'd3
  } cls_e;

  typedef struct packed {
    logic accept;
    logic up_chk;
    logic up_cmp;
    logic pop_rd;
    logic pop_ld;
    logic dn_chk;
    logic dn_cmp;
    logic publish;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic pop_tail;
    logic pos_zero;
    logic no_child;
    logic up_promote;
    logic dn_promote;
  } sts_t;

endpackage

// ----- rtl/btkh_ram.sv -----
// Generic one-write, two-read RAM with registered read data.
// Stand-alone; no package needed.
module btkh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- rtl/btkh_ctrl.sv -----
// Sequencing state machine of the bounded top-k heap.
// Depends on btkh_pkg for the command and status structs.
module btkh_ctrl
  import btkh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_free_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic idle_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_UP_CHK = 8'b0000_0010,
    ST_UP_CMP = 8'b0000_0100,
    ST_POP_RD = 8'b0000_1000,
    ST_POP_LD = 8'b0001_0000,
    ST_DN_CHK = 8'b0010_0000,
    ST_DN_CMP = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (sts_i.cls)
            CLS_SIFT_UP:   state_d = ST_UP_CHK;
            CLS_SIFT_DOWN: state_d = ST_DN_CHK;
            CLS_POP:       state_d = sts_i.pop_tail ? ST_POP_RD : ST_DONE;
            default:       state_d = ST_DONE;
          endcase
        end
      end
      ST_UP_CHK: begin
        cmd_o.up_chk = 1'b1;
        state_d = sts_i.pos_zero ? ST_DONE : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        cmd_o.up_cmp = 1'b1;
        state_d = sts_i.up_promote ? ST_UP_CHK : ST_DONE;
      end
      ST_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_d = ST_POP_LD;
      end
      ST_POP_LD: begin
        cmd_o.pop_ld = 1'b1;
        state_d = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        cmd_o.dn_chk = 1'b1;
        state_d = sts_i.no_child ? ST_DONE : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmd_o.dn_cmp = 1'b1;
        state_d = sts_i.dn_promote ? ST_DN_CHK : ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          cmd_o.publish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule

// ----- rtl/btkh_dp.sv -----
// Datapath of the bounded top-k heap: heap RAM, sift registers, counters.
// Depends on btkh_pkg and instantiates btkh_ram.
module btkh_dp
  import btkh_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic                 func_i,
  input  logic [KEY_WIDTH-1:0] item_key_i,
  input  logic [TAG_WIDTH-1:0] item_tag_i,
  input  logic [CNT_W-1:0]     cap_i,
  input  logic                 order_i,
  output sts_t                 sts_o,
  output kind_e                rep_kind_o,
  output logic [KEY_WIDTH-1:0] rep_key_o,
  output logic [TAG_WIDTH-1:0] rep_tag_o,
  output logic [KEY_WIDTH-1:0] root_key_o,
  output logic [TAG_WIDTH-1:0] root_tag_o,
  output logic [CNT_W-1:0]     count_o
);

  localparam int DW     = KEY_WIDTH + TAG_WIDTH;
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // a ranks strictly nearer the root than b
  function automatic logic worse(input logic [KEY_WIDTH-1:0] a,
                                 input logic [KEY_WIDTH-1:0] b,
                                 input logic                 mode);
    worse = mode ? (a > b) : (a < b);
  endfunction

  logic [DW-1:0]    k_q, k_d;
  logic [DW-1:0]    root_q, root_d;
  logic [DW-1:0]    rep_ent_q, rep_ent_d;
  kind_e            rep_kind_q, rep_kind_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [DW-1:0]     rdata_a, rdata_b;
  logic [ADDR_W-1:0] raddr_a;
  logic              we;
  logic [DW-1:0]     wdata;

  logic [DW-1:0]    in_ent;
  logic             full, beats_root;
  logic [CNT_W-1:0] parent;
  logic [CNT_W:0]   child_l, child_r;
  logic             has_r, pick_r;
  logic [DW-1:0]    pick_ent;
  logic [CNT_W-1:0] pick_idx;
  logic             up_promote, dn_promote, pos_zero, no_child;
  cls_e             cls;

  assign in_ent     = {item_key_i, item_tag_i};
  assign full       = (count_q >= cap_i);
  assign beats_root = worse(root_q[DW-1:TAG_WIDTH], item_key_i, order_i);

  always_comb begin
    if (func_i == FUNC_ADD) begin
      if (!full) begin
        cls = CLS_SIFT_UP;
      end else if (count_q != '0 && beats_root) begin
        cls = CLS_SIFT_DOWN;
      end else begin
        cls = CLS_NONE;
      end
    end else begin
      cls = (count_q == '0) ? CLS_NONE : CLS_POP;
    end
  end

  // Tree links of the current position
  assign parent   = (pos_q - CNT_W'(1)) >> 1;
  assign child_l  = {pos_q, 1'b1};
  assign child_r  = child_l + (CNT_W + 1)'(1);
  assign pos_zero = (pos_q == '0);
  assign no_child = (child_l >= {1'b0, count_q});
  assign has_r    = (child_r < {1'b0, count_q});

  assign pick_r   = has_r && worse(rdata_b[DW-1:TAG_WIDTH], rdata_a[DW-1:TAG_WIDTH], order_i);
  assign pick_ent = pick_r ? rdata_b : rdata_a;
  assign pick_idx = pick_r ? CNT_W'(child_r) : CNT_W'(child_l);

  assign up_promote = worse(k_q[DW-1:TAG_WIDTH], rdata_a[DW-1:TAG_WIDTH], order_i);
  assign dn_promote = worse(pick_ent[DW-1:TAG_WIDTH], k_q[DW-1:TAG_WIDTH], order_i);

  // Read the last entry on pop, the parent on sift up, the children otherwise
  always_comb begin
    if (cmd_i.pop_rd) begin
      raddr_a = ADDR_W'(count_q);
    end else if (cmd_i.up_chk) begin
      raddr_a = ADDR_W'(parent);
    end else begin
      raddr_a = ADDR_W'(child_l);
    end
  end

  assign we = (cmd_i.up_chk && pos_zero) || cmd_i.up_cmp ||
              (cmd_i.dn_chk && no_child) || cmd_i.dn_cmp;

  always_comb begin
    if (cmd_i.up_cmp && up_promote) begin
      wdata = rdata_a;
    end else if (cmd_i.dn_cmp && dn_promote) begin
      wdata = pick_ent;
    end else begin
      wdata = k_q;
    end
  end

  btkh_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (ADDR_W'(pos_q)),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(ADDR_W'(child_r)),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  always_comb begin
    k_d        = k_q;
    pos_d      = pos_q;
    count_d    = count_q;
    rep_kind_d = rep_kind_q;
    rep_ent_d  = rep_ent_q;
    root_d     = root_q;

    if (cmd_i.accept) begin
      case (cls)
        CLS_SIFT_UP: begin
          k_d        = in_ent;
          pos_d      = count_q;
          count_d    = count_q + CNT_W'(1);
          rep_kind_d = KIND_ADDED;
          rep_ent_d  = '0;
        end
        CLS_SIFT_DOWN: begin
          k_d        = in_ent;
          pos_d      = '0;
          rep_kind_d = KIND_EVICTED;
          rep_ent_d  = root_q;
        end
        CLS_POP: begin
          pos_d      = '0;
          count_d    = count_q - CNT_W'(1);
          rep_kind_d = KIND_POPPED;
          rep_ent_d  = root_q;
        end
        default: begin
          rep_kind_d = (func_i == FUNC_ADD) ? KIND_REJECTED : KIND_EMPTY;
          rep_ent_d  = (func_i == FUNC_ADD) ? in_ent : '0;
        end
      endcase
    end

    if (cmd_i.pop_ld) begin
      k_d = rdata_a;
    end
    if (cmd_i.up_cmp && up_promote) begin
      pos_d = parent;
    end
    if (cmd_i.dn_cmp && dn_promote) begin
      pos_d = pick_idx;
    end
    // Mirror every write to the top entry
    if (we && pos_zero) begin
      root_d = wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rep_kind_q <= KIND_ADDED;
    end else begin
      count_q    <= count_d;
      rep_kind_q <= rep_kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    pos_q     <= pos_d;
    rep_ent_q <= rep_ent_d;
    root_q    <= root_d;
  end

  assign sts_o.cls        = cls;
  assign sts_o.pop_tail   = (count_q > CNT_W'(1));
  assign sts_o.pos_zero   = pos_zero;
  assign sts_o.no_child   = no_child;
  assign sts_o.up_promote = up_promote;
  assign sts_o.dn_promote = dn_promote;

  assign rep_kind_o = rep_kind_q;
  assign rep_key_o  = rep_ent_q[DW-1:TAG_WIDTH];
  assign rep_tag_o  = rep_ent_q[TAG_WIDTH-1:0];
  assign root_key_o = (count_q != '0) ? root_q[DW-1:TAG_WIDTH] : '0;
  assign root_tag_o = (count_q != '0) ? root_q[TAG_WIDTH-1:0] : '0;
  assign count_o    = count_q;

endmodule

// ----- rtl/bounded_top_k_heap_core.sv -----
// Top level of the bounded top-k heap: configuration registers, result register.
// Depends on btkh_pkg; instantiates btkh_ctrl and btkh_dp.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): func_i selects add (item_key_i,
//   item_tag_i) or pop of the root. A transfer happens when valid is high and
//   stall is low. One item is worked on at a time; in_stall_o is high from the
//   cycle after a transfer until the result is placed in the output register.
//   Output channel (out_valid_o / out_stall_i): one result per item, held in a
//   register, so a new item may be taken while a result still waits.
//   Config channel (cfg_valid_i / cfg_ready_o): index 0 capacity_limit
//   (0 acts as 1, values above CAPACITY act as CAPACITY), index 1 order_mode.
//   Ready is high while no item is in flight.
// Sequence: an item walks the heap one level at a time, at most floor(log2(N))
//   levels with N items held; a reject, an empty pop or a pop of the last item
//   walks none. Each heap level takes a RAM read step and then a
//   compare-and-write step on the single write port; a pop first fetches the
//   last entry with a read step and then a load step. The result is loaded
//   into the output register when the work ends.
// Reset: empties the heap (count zero), capacity_limit = min(CAPACITY, 64),
//   order_mode = 0. The RAM is not cleared: entries are only used below count.
// Stall: when out_stall_i holds a result, the core finishes the next item and
//   waits with it until the output register frees up.
module bounded_top_k_heap_core
  import btkh_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [KEY_WIDTH-1:0]  item_key_i,
  input  logic [TAG_WIDTH-1:0]  item_tag_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     out_kind_o,
  output logic [KEY_WIDTH-1:0]  out_key_o,
  output logic [TAG_WIDTH-1:0]  out_tag_o,
  output logic [KEY_WIDTH-1:0]  root_key_o,
  output logic [TAG_WIDTH-1:0]  root_tag_o,
  output logic [CNT_W-1:0]      item_count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CAP_RESET = (CAPACITY < 64) ? CAPACITY : 64;

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic out_free;

  logic [CNT_W-1:0] cap_q, cap_d;
  logic             order_q, order_d;
  logic [CNT_W-1:0] cap_wr;

  kind_e                rep_kind;
  logic [KEY_WIDTH-1:0] rep_key, root_key;
  logic [TAG_WIDTH-1:0] rep_tag, root_tag;
  logic [CNT_W-1:0]     count;

  logic                 out_valid_q, out_valid_d;
  kind_e                out_kind_q;
  logic [KEY_WIDTH-1:0] out_key_q, root_key_q;
  logic [TAG_WIDTH-1:0] out_tag_q, root_tag_q;
  logic [CNT_W-1:0]     count_out_q;

  // Take new work only when the core is idle
  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Clamp the written capacity into the built range
  always_comb begin
    if (cfg_data_i == '0) begin
      cap_wr = CNT_W'(1);
    end else if (32'(cfg_data_i) > 32'(CAPACITY)) begin
      cap_wr = CNT_W'(CAPACITY);
    end else begin
      cap_wr = CNT_W'(cfg_data_i);
    end
  end

  always_comb begin
    cap_d   = cap_q;
    order_d = order_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CAPACITY_LIMIT: cap_d   = cap_wr;
        CFG_ORDER_MODE:     order_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CNT_W'(CAP_RESET);
      order_q <= 1'b0;
    end else begin
      cap_q   <= cap_d;
      order_q <= order_d;
    end
  end

  btkh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .out_free_i(out_free),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .idle_o    (idle)
  );

  btkh_dp #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH),
    .TAG_WIDTH(TAG_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .func_i    (func_i),
    .item_key_i(item_key_i),
    .item_tag_i(item_tag_i),
    .cap_i     (cap_q),
    .order_i   (order_q),
    .sts_o     (sts),
    .rep_kind_o(rep_kind),
    .rep_key_o (rep_key),
    .rep_tag_o (rep_tag),
    .root_key_o(root_key),
    .root_tag_o(root_tag),
    .count_o   (count)
  );

  // Result register: load on publish, drop when the receiver takes it
  assign out_valid_d = cmd.publish || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.publish) begin
      out_kind_q  <= rep_kind;
      out_key_q   <= rep_key;
      out_tag_q   <= rep_tag;
      root_key_q  <= root_key;
      root_tag_q  <= root_tag;
      count_out_q <= count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_key_o    = out_key_q;
  assign out_tag_o    = out_tag_q;
  assign root_key_o   = root_key_q;
  assign root_tag_o   = root_tag_q;
  assign item_count_o = count_out_q;

endmodule

// ----- rtl/btkh_checker.sv -----
// Port-level checks of the bounded top-k heap, bound to the top level.
// Depends on btkh_pkg for result kind codes.
module btkh_checker
  import btkh_pkg::*;
#(
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [KIND_W-1:0]    out_kind_o,
  input logic [KEY_WIDTH-1:0] out_key_o,
  input logic [TAG_WIDTH-1:0] out_tag_o,
  input logic [KEY_WIDTH-1:0] root_key_o,
  input logic [TAG_WIDTH-1:0] root_tag_o,
  input logic [CNT_W-1:0]     item_count_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o) &&
      $stable(out_key_o) && $stable(item_count_o))
    else $error("stalled result changed");

  // One item at a time: busy right after a transfer
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again without processing");

  a_empty_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_count_o == '0 |-> root_key_o == '0 && root_tag_o == '0)
    else $error("empty heap shows a root");

  a_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_ADDED || out_kind_o == KIND_EMPTY) |->
      out_key_o == '0 && out_tag_o == '0)
    else $error("report item on add or empty pop");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_EMPTY |-> item_count_o == '0)
    else $error("empty pop with items held");

endmodule

bind bounded_top_k_heap_core btkh_checker #(
  .KEY_WIDTH(KEY_WIDTH),
  .TAG_WIDTH(TAG_WIDTH)
) u_btkh_checker (.*);
